FILE: src/bank_switch_mapper_scanline_irq_core_defines.svh
// assertion macros for the mapper core
// clk and arst_n are taken from the module that uses them
`ifndef BANK_SWITCH_MAPPER_SCANLINE_IRQ_CORE_DEFINES_SVH
`define BANK_SWITCH_MAPPER_SCANLINE_IRQ_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define BSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define BSM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSM_ASSERT(lbl, prop, msg)
`define BSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/bsmirq_pkg.sv
`timescale 1ns / 1ps

package bsmirq_pkg;

	// bus access kinds
	localparam logic [1:0] MODE_CPU_RD = 2'd0;
	localparam logic [1:0] MODE_CPU_WR = 2'd1;
	localparam logic [1:0] MODE_PPU_RD = 2'd2;
	localparam logic [1:0] MODE_PPU_WR = 2'd3;

	// result targets
	typedef enum logic [2:0] {
		TGT_NONE    = 3'd0,
		TGT_PRG_ROM = 3'd1,
		TGT_SRAM    = 3'd2,
		TGT_CHR_ROM = 3'd3,
		TGT_CHR_RAM = 3'd4,
		TGT_NAMETBL = 3'd5,
		TGT_XVRAM   = 3'd6,
		TGT_PALETTE = 3'd7
	} target_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 14;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRAM_SIZE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_RST = 3'd5;

	// mapper register decode
	localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
	localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
	localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
	localparam logic [15:0] REG_MIRRORING   = 16'hA000;
	localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
	localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
	localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
	localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

	// bank register reset values
	typedef logic [7:0] bank_arr_t [8];
	localparam bank_arr_t BANK_RESET = '{8'd0, 8'd1, 8'd0, 8'd1, 8'd2, 8'd3, 8'd0, 8'd0};

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} seq_state_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic       load;
		logic       step;
		logic [2:0] bit_idx;
		logic       commit;
	} seq_ctrl_t;

	// remainder unit status
	typedef struct packed {
		logic [7:0] rem;
		logic [8:0] divisor;
	} mod_stat_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] address;
		logic [7:0]  data;
	} req_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [20:0] mapped_address;
		logic        write_enable;
		logic [7:0]  write_data;
		logic        irq_line;
	} rsp_t;

endpackage

FILE: src/bank_switch_mapper_scanline_irq_core.sv
`timescale 1ns / 1ps
`include "bank_switch_mapper_scanline_irq_core_defines.svh"
// Bank switching cartridge mapper with a scanline interrupt counter.
// req channel (valid/ready): one CPU or PPU bus access (mode, address, data).
// rsp channel (valid/ready): target memory, offset in it, write enable and
// data, and the interrupt level after the access.
// cfg port: cfg_we/cfg_index/cfg_data write the cartridge description;
// the user must write it only while no transaction is in flight; the core does not enforce this.
// After acceptance the bit-serial remainder unit (bank value modulo bank
// count) runs 8 steps; then the sequencer commits the mapper state and
// loads the output register, waiting first if that register is still full.
// req_ready is high only while the sequencer is idle, so a new access is
// not taken until the previous one has been committed.
// The output register decouples the two sides: the next access is taken
// while a finished result waits; if the receiver stalls, the sequencer
// holds the following result until the register is free.
// Reset (arst_n low) returns the configuration, bank registers and IRQ
// state to their defaults and empties the output register.
module bank_switch_mapper_scanline_irq_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  bsmirq_pkg::req_t                    req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output bsmirq_pkg::rsp_t                    rsp,
	input  logic                                cfg_we,
	input  logic [bsmirq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bsmirq_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bsmirq_pkg::*;

	// configuration
	logic [8:0]  prg_count_q, chr_count_q;
	logic [13:0] sram_size_q;
	logic        chr_is_ram_q, four_screen_q, mirror_rst_q;

	// mapper state
	logic [7:0] bank_select_q;
	logic [7:0] bank_regs_q [8];
	logic       vmirror_q;
	logic [7:0] irq_latch_q, irq_count_q;
	logic       reload_q, irq_en_q, irq_asr_q, prev_a12_q;

	// transaction in flight and output register
	req_t       item_q;
	rsp_t       rsp_q;
	logic       rsp_valid_q;

	seq_ctrl_t  ctrl;
	mod_stat_t  mstat;
	logic       slot_free;

	logic [8:0] prg_cnt, chr_cnt;

	// clamped bank counts
	always_comb begin
		if (prg_count_q < 9'd2) prg_cnt = 9'd2;
		else if (prg_count_q > 9'd256) prg_cnt = 9'd256;
		else prg_cnt = prg_count_q;
		if (chr_count_q == 9'd0) chr_cnt = 9'd1;
		else if (chr_count_q > 9'd256) chr_cnt = 9'd256;
		else chr_cnt = chr_count_q;
	end

	// operand and divisor for the remainder unit, from the incoming access
	logic [2:0] rd_idx;
	logic [7:0] operand, bd_value;
	logic [8:0] divisor;
	logic       in_half;

	always_comb begin
		in_half  = req.address[12] ^ bank_select_q[7];
		bd_value = (bank_select_q[2:0] <= 3'd1) ? (req.data & 8'hFE) : req.data;
		if (!req.mode[1]) begin
			rd_idx = (req.address[14:13] == 2'd1) ? 3'd7 : 3'd6;
		end else if (!in_half) begin
			rd_idx = {2'b00, req.address[11]};
		end else begin
			rd_idx = {1'b0, req.address[11:10]} + 3'd2;
		end
		if (req.mode == MODE_CPU_WR) begin
			operand = bd_value;
			divisor = (bank_select_q[2:0] >= 3'd6) ? prg_cnt : chr_cnt;
		end else begin
			operand = bank_regs_q[rd_idx];
			divisor = req.mode[1] ? chr_cnt : prg_cnt;
		end
	end

	bsmirq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.slot_free (slot_free),
		.req_ready (req_ready),
		.ctrl      (ctrl)
	);

	bsmirq_mod_unit u_mod (
		.clk     (clk),
		.ctrl    (ctrl),
		.operand (operand),
		.divisor (divisor),
		.stat    (mstat)
	);

	assign slot_free = !rsp_valid_q || rsp_ready;

	// latch the accepted access
	always_ff @(posedge clk) begin
		if (ctrl.load) item_q <= req;
	end

	// result and state update for the access in flight
	logic [15:0] a;
	logic [13:0] pa;
	logic [7:0]  d;
	logic        cpu_acc, cpu_wr, ppu_wr, reg_wr, pat_acc, pat_clk;
	logic [13:0] sram_mask;
	logic [8:0]  chr_sum, chr_wrap, prg_bank;
	logic [7:0]  chr_bank;
	logic [1:0]  win, quad;
	logic [4:0]  pal;
	logic [15:0] reg_code;
	target_t     tgt;
	logic [20:0] mapped;
	logic        we;
	logic [7:0]  cnt_n;
	logic        reload_n, asr_n;

	always_comb begin
		a         = item_q.address;
		d         = item_q.data;
		pa        = a[13:0];
		cpu_acc   = !item_q.mode[1];
		cpu_wr    = item_q.mode == MODE_CPU_WR;
		ppu_wr    = item_q.mode == MODE_PPU_WR;
		reg_wr    = cpu_wr && a[15];
		pat_acc   = !cpu_acc && (pa[13] == 1'b0);
		pat_clk   = pat_acc && !ppu_wr && !prev_a12_q && pa[12];
		reg_code  = a & REG_DECODE_MASK;
		sram_mask = sram_size_q - 14'd1;
		win       = a[14:13];
		quad      = pa[11:10];
		pal       = pa[4:0];

		// character bank: 2K windows add A10 and wrap at the count
		chr_sum  = {1'b0, mstat.rem} + {8'd0, pa[10]};
		chr_wrap = (chr_sum >= chr_cnt) ? (chr_sum - chr_cnt) : chr_sum;
		if ((pa[12] ^ bank_select_q[7]) == 1'b0) chr_bank = chr_wrap[7:0];
		else chr_bank = mstat.rem;

		// program bank: fixed last bank, swappable second-last
		if (win == 2'd3) prg_bank = prg_cnt - 9'd1;
		else if (win == 2'd1) prg_bank = {1'b0, mstat.rem};
		else if ((win == 2'd0) != bank_select_q[6]) prg_bank = {1'b0, mstat.rem};
		else prg_bank = prg_cnt - 9'd2;

		tgt    = TGT_NONE;
		mapped = 21'd0;
		we     = 1'b0;
		if (cpu_acc) begin
			if (a[15:13] == 3'b011) begin
				if (sram_size_q != 14'd0) begin
					tgt    = TGT_SRAM;
					mapped = {8'd0, a[12:0] & sram_mask[12:0]};
					we     = cpu_wr;
				end
			end else if (a[15] && !cpu_wr) begin
				tgt    = TGT_PRG_ROM;
				mapped = {prg_bank[7:0], a[12:0]};
			end
		end else if (pat_acc) begin
			tgt    = chr_is_ram_q ? TGT_CHR_RAM : TGT_CHR_ROM;
			mapped = {3'd0, chr_bank, pa[9:0]};
			we     = ppu_wr && chr_is_ram_q;
		end else if (pa < 14'h3F00) begin
			tgt = TGT_NAMETBL;
			we  = ppu_wr;
			if (four_screen_q) begin
				if (quad[1]) tgt = TGT_XVRAM;
				mapped = {10'd0, quad[0], pa[9:0]};
			end else if (vmirror_q) begin
				mapped = {10'd0, quad[0], pa[9:0]};
			end else begin
				mapped = {10'd0, quad[1], pa[9:0]};
			end
		end else begin
			tgt = TGT_PALETTE;
			we  = ppu_wr;
			if ((pal & 5'h13) == 5'h10) mapped = {17'd0, pal[3:0]};
			else mapped = {16'd0, pal};
		end

		// scanline counter clock
		cnt_n    = irq_count_q;
		reload_n = reload_q;
		asr_n    = irq_asr_q;
		if (reg_wr && reg_code == REG_IRQ_RELOAD) reload_n = 1'b1;
		if (reg_wr && reg_code == REG_IRQ_DISABLE) asr_n = 1'b0;
		if (pat_clk) begin
			if (reload_q) begin
				cnt_n    = irq_latch_q;
				reload_n = 1'b0;
			end else if (irq_count_q != 8'd0) begin
				cnt_n = irq_count_q - 8'd1;
			end
			if (cnt_n == 8'd0) begin
				reload_n = 1'b1;
				if (irq_en_q && irq_latch_q != 8'd0) asr_n = 1'b1;
			end
		end
	end

	// configuration registers and mapper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q   <= 9'd2;
			chr_count_q   <= 9'd8;
			sram_size_q   <= 14'd8192;
			chr_is_ram_q  <= 1'b0;
			four_screen_q <= 1'b0;
			mirror_rst_q  <= 1'b0;
			bank_select_q <= 8'd0;
			bank_regs_q   <= BANK_RESET;
			vmirror_q     <= 1'b0;
			irq_latch_q   <= 8'd0;
			irq_count_q   <= 8'd0;
			reload_q      <= 1'b0;
			irq_en_q      <= 1'b0;
			irq_asr_q     <= 1'b0;
			prev_a12_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PRG_COUNT:  prg_count_q <= cfg_data[8:0];
					CFG_CHR_COUNT:  chr_count_q <= cfg_data[8:0];
					CFG_SRAM_SIZE:  sram_size_q <= cfg_data;
					CFG_CHR_IS_RAM: chr_is_ram_q <= cfg_data[0];
					CFG_FOUR_SCR:   four_screen_q <= cfg_data[0];
					CFG_MIRROR_RST: begin
						mirror_rst_q <= cfg_data[0];
						vmirror_q    <= cfg_data[0];
					end
					default: mirror_rst_q <= mirror_rst_q;
				endcase
			end
			if (ctrl.commit) begin
				irq_count_q <= cnt_n;
				reload_q    <= reload_n;
				irq_asr_q   <= asr_n;
				if (pat_acc && !ppu_wr) prev_a12_q <= pa[12];
				if (reg_wr) begin
					unique case (reg_code)
						REG_BANK_SELECT: bank_select_q <= d;
						REG_BANK_DATA:   bank_regs_q[bank_select_q[2:0]] <= mstat.rem;
						REG_MIRRORING:   vmirror_q <= ~d[0];
						REG_IRQ_LATCH:   irq_latch_q <= d;
						REG_IRQ_DISABLE: irq_en_q <= 1'b0;
						REG_IRQ_ENABLE:  irq_en_q <= 1'b1;
						default:         irq_latch_q <= irq_latch_q;
					endcase
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			rsp_q.target         <= tgt;
			rsp_q.mapped_address <= mapped;
			rsp_q.write_enable   <= we;
			rsp_q.write_data     <= we ? d : 8'd0;
			rsp_q.irq_line       <= asr_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`BSM_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready, "accepted while busy")
	`BSM_ASSERT(a_commit_slot_free, ctrl.commit |-> (!rsp_valid_q || rsp_ready), "result overwritten")
	`BSM_ASSERT(a_rem_in_range, ctrl.commit |-> (mstat.rem < mstat.divisor), "remainder not reduced")
	`BSM_ASSERT(a_irq_from_pattern, $rose(irq_asr_q) |-> $past(ctrl.commit && pat_clk), "irq without clock")
	`BSM_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |=> (req_ready && !rsp_valid), "not idle in reset")

endmodule

FILE: src/bsmirq_mod_unit.sv
`timescale 1ns / 1ps

module bsmirq_mod_unit (
	input  logic                  clk,
	input  bsmirq_pkg::seq_ctrl_t ctrl,
	input  logic [7:0]            operand,
	input  logic [8:0]            divisor,
	output bsmirq_pkg::mod_stat_t stat
);
	import bsmirq_pkg::*;

	logic [7:0] op_q;
	logic [8:0] div_q;
	logic [7:0] rem_q;
	logic [8:0] shifted;
	logic [8:0] diff;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	assign shifted = {rem_q, op_q[ctrl.bit_idx]};
	assign diff    = shifted - div_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			op_q  <= operand;
			div_q <= divisor;
			rem_q <= 8'd0;
		end else if (ctrl.step) begin
			if (shifted >= div_q) begin
				rem_q <= diff[7:0];
			end else begin
				rem_q <= shifted[7:0];
			end
		end
	end

	assign stat.rem     = rem_q;
	assign stat.divisor = div_q;

endmodule

FILE: src/bsmirq_seq.sv
`timescale 1ns / 1ps

module bsmirq_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  slot_free,
	output logic                  req_ready,
	output bsmirq_pkg::seq_ctrl_t ctrl
);
	import bsmirq_pkg::*;

	seq_state_t state_q, state_n;
	logic [2:0] cnt_q;

	// state register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 3'd7;
		end else begin
			state_q <= state_n;
			if (state_q == ST_IDLE) begin
				cnt_q <= 3'd7;
			end else if (state_q == ST_RUN) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (req_valid) state_n = ST_RUN;
			ST_RUN:  if (cnt_q == 3'd0) state_n = ST_DONE;
			ST_DONE: if (slot_free) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready    = 1'b0;
		ctrl.load    = 1'b0;
		ctrl.step    = 1'b0;
		ctrl.commit  = 1'b0;
		ctrl.bit_idx = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				ctrl.load = req_valid;
			end
			ST_RUN:  ctrl.step = 1'b1;
			ST_DONE: ctrl.commit = slot_free;
			default: req_ready = 1'b0;
		endcase
	end

endmodule

FILE: test/mapper_access_checker.sv
`timescale 1ns / 1ps

module mapper_access_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic                              req_ready,
	input  bsmirq_pkg::req_t                  req,
	input  logic                              rsp_valid,
	input  logic                              rsp_ready,
	input  bsmirq_pkg::rsp_t                  rsp,
	input  logic                              cfg_we,
	input  logic [bsmirq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsmirq_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                fail_count,
	output int                                pending,
	output int                                checked
);
	import bsmirq_pkg::*;

	// bank register roles
	localparam int PRG_WIN_A   = 6;
	localparam int PRG_WIN_B   = 7;
	localparam int CHR_1K_BASE = 2;

	// ppu address map
	localparam logic [13:0] NT_BASE  = 14'h2000;
	localparam logic [13:0] PAL_BASE = 14'h3F00;

	// cartridge description
	logic [8:0]  prg_cfg;
	logic [8:0]  chr_cfg;
	logic [13:0] sram_cfg;
	logic        chr_ram_cfg;
	logic        four_cfg;

	// mapper state
	logic [7:0]  sel_q;
	bank_arr_t   banks;
	logic        vmirror;
	logic [7:0]  latch_q;
	logic [7:0]  count_q;
	logic        reload_q;
	logic        irq_en_q;
	logic        irq_q;
	logic        a12_q;

	// translations still waiting for their result transaction
	rsp_t        pending_maps [$];
	int          fails;
	int          n_checked;

	// works out the result of one bus access and advances the mapper state
	function automatic rsp_t translate_access(req_t r);
		rsp_t        o;
		logic [13:0] pa;
		logic [4:0]  pal;
		logic [1:0]  win;
		logic [1:0]  q;
		logic        wr;
		int          prg_n;
		int          chr_n;
		int          bank;

		o = '0;
		wr = 1'b0;
		prg_n = (prg_cfg < 2) ? 2 : (prg_cfg > 256) ? 256 : int'(prg_cfg);
		chr_n = (chr_cfg < 1) ? 1 : (chr_cfg > 256) ? 256 : int'(chr_cfg);

		if (r.mode == MODE_CPU_RD || r.mode == MODE_CPU_WR) begin
			if (r.address[15:13] == 3'b011) begin
				// save ram, masked by its size
				if (sram_cfg != 0) begin
					o.target = TGT_SRAM;
					o.mapped_address = 21'(r.address[12:0] & 13'(sram_cfg - 14'd1));
					wr = (r.mode == MODE_CPU_WR);
				end
			end else if (r.address[15]) begin
				if (r.mode == MODE_CPU_RD) begin
					// program rom windows, last bank fixed
					win = r.address[14:13];
					if (win == 2'd3)
						bank = prg_n - 1;
					else if (win == 2'd1)
						bank = banks[PRG_WIN_B] % prg_n;
					else if ((win == 2'd0) != sel_q[6])
						bank = banks[PRG_WIN_A] % prg_n;
					else
						bank = prg_n - 2;
					o.target = TGT_PRG_ROM;
					o.mapped_address = 21'(bank * 8192 + r.address[12:0]);
				end else begin
					// mapper register writes
					case (r.address & REG_DECODE_MASK)
						REG_BANK_SELECT: sel_q = r.data;
						REG_BANK_DATA: begin
							if (sel_q[2:0] <= 3'd1)
								banks[sel_q[2:0]] = 8'((r.data & 8'hFE) % chr_n);
							else if (sel_q[2:0] <= 3'd5)
								banks[sel_q[2:0]] = 8'(r.data % chr_n);
							else
								banks[sel_q[2:0]] = 8'(r.data % prg_n);
						end
						REG_MIRRORING: vmirror = ~r.data[0];
						REG_IRQ_LATCH: latch_q = r.data;
						REG_IRQ_RELOAD: reload_q = 1'b1;
						REG_IRQ_DISABLE: begin
							irq_q = 1'b0;
							irq_en_q = 1'b0;
						end
						REG_IRQ_ENABLE: irq_en_q = 1'b1;
						default: ;
					endcase
				end
			end
		end else begin
			pa = r.address[13:0];
			wr = (r.mode == MODE_PPU_WR);
			if (pa < NT_BASE) begin
				// pattern reads clock the scanline counter on rising a12
				if (!wr) begin
					if (!a12_q && pa[12]) begin
						if (reload_q) begin
							count_q = latch_q;
							reload_q = 1'b0;
						end else if (count_q != 8'd0) begin
							count_q = count_q - 8'd1;
						end
						if (count_q == 8'd0) begin
							reload_q = 1'b1;
							if (irq_en_q && latch_q != 8'd0)
								irq_q = 1'b1;
						end
					end
					a12_q = pa[12];
				end
				// character banks, halves swapped by a12 inversion
				if ((pa[12] ^ sel_q[7]) == 1'b0) begin
					bank = banks[pa[11]] % chr_n + pa[10];
					if (bank >= chr_n)
						bank = bank - chr_n;
				end else begin
					bank = banks[CHR_1K_BASE + pa[11:10]] % chr_n;
				end
				o.target = chr_ram_cfg ? TGT_CHR_RAM : TGT_CHR_ROM;
				o.mapped_address = 21'(bank * 1024 + pa[9:0]);
				wr = wr && chr_ram_cfg;
			end else if (pa < PAL_BASE) begin
				// nametables, including the mirror above 3000
				q = pa[11:10];
				o.target = (four_cfg && q[1]) ? TGT_XVRAM : TGT_NAMETBL;
				o.mapped_address = 21'({(four_cfg || vmirror) ? q[0] : q[1], pa[9:0]});
			end else begin
				// palette with the sprite backdrop entries folded down
				pal = pa[4:0];
				if (pal[4] && pal[1:0] == 2'd0)
					pal[4] = 1'b0;
				o.target = TGT_PALETTE;
				o.mapped_address = 21'(pal);
			end
		end

		o.write_enable = wr;
		o.write_data = wr ? r.data : 8'd0;
		o.irq_line = irq_q;
		return o;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fails++;
		end
	endtask

	// follow configuration writes, accesses and results
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			prg_cfg = 9'd2;
			chr_cfg = 9'd8;
			sram_cfg = 14'd8192;
			chr_ram_cfg = 1'b0;
			four_cfg = 1'b0;
			sel_q = 8'd0;
			banks = BANK_RESET;
			vmirror = 1'b0;
			latch_q = 8'd0;
			count_q = 8'd0;
			reload_q = 1'b0;
			irq_en_q = 1'b0;
			irq_q = 1'b0;
			a12_q = 1'b0;
			pending_maps.delete();
			fails = 0;
			n_checked = 0;
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PRG_COUNT: prg_cfg = cfg_data[8:0];
					CFG_CHR_COUNT: chr_cfg = cfg_data[8:0];
					CFG_SRAM_SIZE: sram_cfg = cfg_data;
					CFG_CHR_IS_RAM: chr_ram_cfg = cfg_data[0];
					CFG_FOUR_SCR: four_cfg = cfg_data[0];
					CFG_MIRROR_RST: vmirror = cfg_data[0];
					default: ;
				endcase
			end

			// result side first: a result never belongs to this edge's access
			if (rsp_valid && rsp_ready) begin
				if (pending_maps.size() == 0) begin
					$error("result transaction with no access outstanding");
					fails++;
				end else begin
					want = pending_maps.pop_front();
					check_field("target", want.target, rsp.target);
					check_field("mapped_address", want.mapped_address, rsp.mapped_address);
					check_field("write_enable", want.write_enable, rsp.write_enable);
					check_field("write_data", want.write_data, rsp.write_data);
					check_field("irq_line", want.irq_line, rsp.irq_line);
					n_checked++;
				end
			end

			if (req_valid && req_ready)
				pending_maps.push_back(translate_access(req));

			fail_count <= fails;
			pending <= pending_maps.size();
			checked <= n_checked;
		end
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import bsmirq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 235;
	localparam int SETTLE_CYCLES  = 30;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int checked;
	int items_sent = 0;
	int settings_run = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	bank_switch_mapper_scanline_irq_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mapper_access_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 14);
		return $urandom_range(20, 60);
	endfunction

	// one access transaction, valid held until taken
	task automatic send_access(input logic [1:0] mode, input logic [15:0] addr,
			input logic [7:0] data);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= '{mode: mode, address: addr, data: data};
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	// mapper register write at a random mirror of its address
	task automatic send_reg(input logic [15:0] base, input logic [7:0] data);
		send_access(MODE_CPU_WR, base | (16'($urandom) & ~REG_DECODE_MASK), data);
	endtask

	// stop sending and let every outstanding result arrive
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
	endtask

	// new cartridge description, written while the core is idle
	task automatic set_cartridge(input int prg, input int chr, input int sram,
			input bit chr_ram, input bit four, input bit mirror);
		wait_drained();
		write_reg(CFG_PRG_COUNT, prg);
		write_reg(CFG_CHR_COUNT, chr);
		write_reg(CFG_SRAM_SIZE, sram);
		write_reg(CFG_CHR_IS_RAM, chr_ram);
		write_reg(CFG_FOUR_SCR, four);
		write_reg(CFG_MIRROR_RST, mirror);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// random traffic over all access kinds, with some scanline sequences aimed at the irq
	task automatic random_access();
		int          kind;
		int          n;
		logic [15:0] a;
		logic [7:0]  d;
		kind = $urandom_range(0, 99);
		a = 16'($urandom);
		d = 8'($urandom);
		if (kind < 25) begin
			send_access(MODE_PPU_RD, {a[15:14], 1'b0, a[12:0]}, d);
		end else if (kind < 33) begin
			send_access(MODE_PPU_WR, {a[15:14], 1'b0, a[12:0]}, d);
		end else if (kind < 48) begin
			send_access(MODE_CPU_WR, {1'b1, a[14:0]}, d);
		end else if (kind < 58) begin
			send_access(MODE_CPU_RD, {1'b1, a[14:0]}, d);
		end else if (kind < 68) begin
			send_access($urandom_range(0, 1) ? MODE_CPU_WR : MODE_CPU_RD,
				{3'b011, a[12:0]}, d);
		end else if (kind < 80) begin
			send_access($urandom_range(0, 1) ? MODE_PPU_WR : MODE_PPU_RD,
				{a[15:14], 1'b1, a[12:0]}, d);
		end else if (kind < 88) begin
			send_access(2'($urandom), a, d);
		end else begin
			// irq setup, then a run of scanlines: a12 low then high
			if ($urandom_range(0, 3) == 0)
				send_reg(REG_IRQ_LATCH, $urandom_range(0, 3) == 0 ?
					8'($urandom) : 8'($urandom_range(0, 6)));
			if ($urandom_range(0, 2) == 0)
				send_reg(REG_IRQ_RELOAD, 8'($urandom));
			if ($urandom_range(0, 3) == 0)
				send_reg(REG_IRQ_DISABLE, 8'($urandom));
			if ($urandom_range(0, 1) == 0)
				send_reg(REG_IRQ_ENABLE, 8'($urandom));
			n = $urandom_range(1, 8);
			repeat (n) begin
				a = 16'($urandom);
				send_access(MODE_PPU_RD, {a[15:14], 2'b00, a[11:0]}, a[7:0]);
				a = 16'($urandom);
				send_access(MODE_PPU_RD, {a[15:14], 2'b01, a[11:0]}, a[7:0]);
			end
		end
	endtask

	// result side back-pressure
	initial begin
		int hold;
		int run;
		forever begin
			hold = pick_gap();
			if (hold > 0) begin
				rsp_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			run = $urandom_range(1, 8);
			repeat (run) @(posedge clk);
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", quiet_cycles);
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus and verdict
	initial begin
		int start;
		int sram;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset description
		send_access(MODE_CPU_RD, 16'h0000, 8'h00);
		send_access(MODE_CPU_WR, 16'h5FFF, 8'hFF);
		send_access(MODE_CPU_RD, 16'h6000, 8'h00);
		send_access(MODE_CPU_WR, 16'h7FFF, 8'hFF);
		send_access(MODE_CPU_RD, 16'h8000, 8'h00);
		send_access(MODE_CPU_RD, 16'hFFFF, 8'h00);
		send_access(MODE_CPU_WR, REG_BANK_SELECT, 8'hC7);
		send_access(MODE_CPU_WR, REG_BANK_DATA, 8'hFF);
		send_access(MODE_CPU_RD, 16'hA000, 8'h00);
		send_access(MODE_CPU_RD, 16'h8000, 8'h00);
		send_access(MODE_CPU_WR, REG_MIRRORING, 8'h00);
		// prg ram protect is ignored
		send_access(MODE_CPU_WR, 16'hA001, 8'hFF);
		send_access(MODE_CPU_WR, REG_IRQ_LATCH, 8'h01);
		send_access(MODE_CPU_WR, REG_IRQ_RELOAD, 8'h00);
		send_access(MODE_CPU_WR, REG_IRQ_ENABLE, 8'h00);
		send_access(MODE_PPU_RD, 16'h0000, 8'h00);
		send_access(MODE_PPU_RD, 16'h1000, 8'h00);
		send_access(MODE_PPU_RD, 16'h0FFF, 8'h00);
		send_access(MODE_PPU_RD, 16'h1FFF, 8'h00);
		// pattern write to character rom is not enabled
		send_access(MODE_PPU_WR, 16'h0400, 8'h5A);
		send_access(MODE_CPU_WR, REG_IRQ_DISABLE, 8'h00);
		send_access(MODE_PPU_RD, 16'h2000, 8'h00);
		send_access(MODE_PPU_WR, 16'h2C00, 8'h11);
		send_access(MODE_PPU_RD, 16'h3000, 8'h00);
		send_access(MODE_PPU_RD, 16'h3F10, 8'h00);
		send_access(MODE_PPU_WR, 16'h3F1F, 8'hAA);
		send_access(MODE_PPU_RD, 16'hFF14, 8'h00);

		// random part over a series of cartridge descriptions
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_cartridge(2, 1, 0, 1'b1, 1'b1, 1'b1);
				1: set_cartridge(256, 256, 8192, 1'b0, 1'b0, 1'b0);
				2: set_cartridge(0, 0, 16383, 1'b1, 1'b0, 1'b1);
				3: set_cartridge(511, 511, 4096, 1'b0, 1'b1, 1'b0);
				4: set_cartridge(3, 5, 1, 1'b1, 1'b0, 1'b0);
				default: begin
					case ($urandom_range(0, 2))
						0: sram = 0;
						1: sram = 1 << $urandom_range(0, 13);
						default: sram = $urandom_range(0, 16383);
					endcase
					set_cartridge($urandom_range(0, 511), $urandom_range(0, 511), sram,
						1'($urandom), 1'($urandom), 1'($urandom));
				end
			endcase
			calm = (p % 3 == 2);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS)
				random_access();
		end
		calm = 1'b0;

		wait_drained();
		$display("covered %0d bus accesses under %0d cartridge descriptions", items_sent,
			settings_run + 1);
		$display("%0d result transactions compared, %0d mismatches", checked, fail_count);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
